>>> design/gradient_magnitude_edge_stream_defines.svh
// ----------------------------------------------------------------------------
// gradient magnitude edge stream assertion macros
// implication checks that compile away under synthesis
// ----------------------------------------------------------------------------
`ifndef GRADIENT_MAGNITUDE_EDGE_STREAM_DEFINES_SVH
`define GRADIENT_MAGNITUDE_EDGE_STREAM_DEFINES_SVH

`ifndef SYNTHESIS
`define GME_ASSERT_IMP(label, ck, rn, ante, cons) \
  label: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
    else $error("gme assertion failed");
`define GME_ASSERT_NXT(label, ck, rn, ante, cons) \
  label: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
    else $error("gme assertion failed");
`else
`define GME_ASSERT_IMP(label, ck, rn, ante, cons)
`define GME_ASSERT_NXT(label, ck, rn, ante, cons)
`endif

`endif

>>> design/gme_pkg.sv
// ----------------------------------------------------------------------------
// gme_pkg
// shared widths, beat types and helpers of the gradient magnitude edge stream
// ----------------------------------------------------------------------------
package gme_pkg;

  localparam int LS_DEPTH   = 2048;
  localparam int LS_AW      = $clog2(LS_DEPTH);
  localparam int PIX_W      = 8;
  localparam int DIM_W      = 12;
  localparam int POS_W      = 11;
  localparam int SUM_W      = 20;
  localparam int CFG_IDX_W  = 2;
  localparam int HEIGHT_MAX = 2048;

  localparam logic [DIM_W-1:0]     WIDTH_RESET  = 12'd640;
  localparam logic [DIM_W-1:0]     HEIGHT_RESET = 12'd480;
  localparam logic [DIM_W-1:0]     DIM_MIN      = 12'd2;
  localparam logic [PIX_W-1:0]     EDGE_MAX     = 8'd255;

  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 2'd1;

  typedef struct packed {
    logic [PIX_W-1:0] pixel;
  } pixel_beat_t;

  typedef struct packed {
    logic [PIX_W-1:0] edge_res;
    logic [POS_W-1:0] out_col;
    logic [POS_W-1:0] out_row;
    logic             frame_last;
  } result_beat_t;

  typedef struct packed {
    logic busy;
    logic done;
  } sqrt_stat_t;

  function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v,
                                                 input logic [DIM_W-1:0] maxv);
    logic [DIM_W-1:0] r;
    r = v;
    if (v < DIM_MIN) r = DIM_MIN;
    if (v > maxv) r = maxv;
    return r;
  endfunction

endpackage

>>> design/gme_pix_if.sv
// ----------------------------------------------------------------------------
// gme_pix_if
// pixel stream channel: valid, ready and one pixel per beat
// ----------------------------------------------------------------------------
interface gme_pix_if;
  import gme_pkg::*;

  logic        valid;
  logic        ready;
  pixel_beat_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

>>> design/gme_res_if.sv
// ----------------------------------------------------------------------------
// gme_res_if
// result stream channel: valid, ready and one edge result per beat
// ----------------------------------------------------------------------------
interface gme_res_if;
  import gme_pkg::*;

  logic         valid;
  logic         ready;
  result_beat_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

>>> design/gme_line_ram.sv
// ----------------------------------------------------------------------------
// gme_line_ram
// single port synchronous ram with registered read: read data appears in the cycle after its address
// ----------------------------------------------------------------------------
module gme_line_ram #(
  parameter int DEPTH = 2048,
  parameter int WIDTH = 8
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

>>> design/gme_isqrt.sv
// ----------------------------------------------------------------------------
// gme_isqrt
// bit serial floored integer square root, one result bit per cycle,
// saturates at the top code when the operand needs more than 8 root bits
// ----------------------------------------------------------------------------
module gme_isqrt (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  input  logic [gme_pkg::SUM_W-1:0]  s_in,
  output gme_pkg::sqrt_stat_t        stat,
  output logic [gme_pkg::PIX_W-1:0]  root
);
  import gme_pkg::*;

  logic             busy_r;
  logic             done_r;
  logic [2:0]       idx_r;
  logic [PIX_W-1:0] root_r;
  logic [15:0]      s_r;
  logic [PIX_W-1:0] trial;
  logic [15:0]      trial_sq;
  logic             sat;

  assign sat      = (s_in[SUM_W-1:16] != '0);
  assign trial    = root_r | (PIX_W'(1) << idx_r);
  assign trial_sq = {8'b0, trial} * {8'b0, trial};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else if (start) begin
      busy_r <= !sat;
      done_r <= sat;
    end else if (busy_r && idx_r == 3'd0) begin
      busy_r <= 1'b0;
      done_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      root_r <= sat ? EDGE_MAX : '0;
      s_r    <= s_in[15:0];
      idx_r  <= 3'd7;
    end else if (busy_r) begin
      if (trial_sq <= s_r) begin
        root_r <= trial;
      end
      idx_r <= idx_r - 3'd1;
    end
  end

  assign stat.busy = busy_r;
  assign stat.done = done_r;
  assign root      = root_r;

endmodule

>>> design/gradient_magnitude_edge_stream.sv
// ----------------------------------------------------------------------------
// gradient_magnitude_edge_stream
// 2x2 gradient magnitude over a raster pixel stream with a one-row line store
// a new pixel is taken only in the idle state, after the last one has passed
//   the line ram read+write and, for a pixel that closes a window, the 8-step
//   square root (skipped when the root saturates) and the load of the output
//   register, which waits while a held result is not taken
// reset: width 640, height 480, position and neighbor pixels zero; the line
//   ram is not cleared and needs no clearing pass
// ----------------------------------------------------------------------------
`include "gradient_magnitude_edge_stream_defines.svh"

module gradient_magnitude_edge_stream (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_we,
  input  logic [gme_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [gme_pkg::DIM_W-1:0]     cfg_data,
  gme_pix_if.sink                       in_pix,
  gme_res_if.source                     out_res
);
  import gme_pkg::*;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_READ = 2'd1;
  localparam logic [1:0] ST_SQR  = 2'd2;
  localparam logic [1:0] ST_SQRT = 2'd3;

  logic [1:0]       state_r, state_nxt;
  logic [DIM_W-1:0] width_r, height_r;
  logic [POS_W-1:0] col_r, row_r;
  logic [PIX_W-1:0] prev_cur_r, prev_up_r;
  logic [PIX_W-1:0] pix_r;
  logic [9:0]       gx_abs_r, gy_abs_r;
  logic [POS_W-1:0] res_col_r, res_row_r;
  logic             res_last_r;
  logic             out_valid_r;
  result_beat_t     out_data_r;

  logic             accept;
  logic             ls_we;
  logic [PIX_W-1:0] ls_rdata;
  logic [PIX_W-1:0] tr;
  logic [9:0]       gx, gy;
  logic [DIM_W-1:0] col_inc, row_inc;
  logic             emit;
  logic             col_wrap, row_wrap;
  logic [SUM_W-1:0] sq_sum;
  logic             sq_start;
  sqrt_stat_t       sq_stat;
  logic [PIX_W-1:0] sq_root;
  logic             out_load;

  assign accept       = in_pix.valid && in_pix.ready;
  assign in_pix.ready = (state_r == ST_IDLE);
  assign ls_we        = (state_r == ST_READ);
  assign tr           = ls_rdata;

  gme_line_ram #(
    .DEPTH (LS_DEPTH),
    .WIDTH (PIX_W)
  ) u_line_ram (
    .clk   (clk),
    .we    (ls_we),
    .addr  (col_r),
    .wdata (pix_r),
    .rdata (ls_rdata)
  );

  // gradients of the window, two's complement in 10 bits
  assign gx = ({2'b0, tr} + {2'b0, pix_r}) - ({2'b0, prev_up_r} + {2'b0, prev_cur_r});
  assign gy = ({2'b0, prev_cur_r} + {2'b0, pix_r}) - ({2'b0, prev_up_r} + {2'b0, tr});

  assign col_inc  = {1'b0, col_r} + DIM_W'(1);
  assign row_inc  = {1'b0, row_r} + DIM_W'(1);
  assign col_wrap = (col_inc >= width_r);
  assign row_wrap = (row_inc >= height_r);
  assign emit     = (row_r != '0) && (col_r != '0);

  assign sq_sum   = ({10'b0, gx_abs_r} * {10'b0, gx_abs_r})
                  + ({10'b0, gy_abs_r} * {10'b0, gy_abs_r});
  assign sq_start = (state_r == ST_SQR);

  gme_isqrt u_isqrt (
    .clk   (clk),
    .rst_n (rst_n),
    .start (sq_start),
    .s_in  (sq_sum),
    .stat  (sq_stat),
    .root  (sq_root)
  );

  assign out_load = (state_r == ST_SQRT) && sq_stat.done && (!out_valid_r || out_res.ready);

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: if (accept) state_nxt = ST_READ;
      ST_READ: state_nxt = emit ? ST_SQR : ST_IDLE;
      ST_SQR:  state_nxt = ST_SQRT;
      ST_SQRT: if (out_load) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_IDLE;
      width_r    <= WIDTH_RESET;
      height_r   <= HEIGHT_RESET;
      col_r      <= '0;
      row_r      <= '0;
      prev_cur_r <= '0;
      prev_up_r  <= '0;
    end else begin
      state_r <= state_nxt;
      if (cfg_we && (cfg_index == REG_IMAGE_WIDTH || cfg_index == REG_IMAGE_HEIGHT)) begin
        if (cfg_index == REG_IMAGE_WIDTH) begin
          width_r <= clamp_dim(cfg_data, DIM_W'(LS_DEPTH));
        end else begin
          height_r <= clamp_dim(cfg_data, DIM_W'(HEIGHT_MAX));
        end
        // a register write restarts the frame
        col_r      <= '0;
        row_r      <= '0;
        prev_cur_r <= '0;
        prev_up_r  <= '0;
      end else if (state_r == ST_READ) begin
        prev_up_r  <= tr;
        prev_cur_r <= pix_r;
        if (col_wrap) begin
          col_r <= '0;
          row_r <= row_wrap ? '0 : row_inc[POS_W-1:0];
        end else begin
          col_r <= col_inc[POS_W-1:0];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      pix_r <= in_pix.data.pixel;
    end
    if (state_r == ST_READ) begin
      gx_abs_r   <= gx[9] ? (10'd0 - gx) : gx;
      gy_abs_r   <= gy[9] ? (10'd0 - gy) : gy;
      res_col_r  <= col_r - POS_W'(1);
      res_row_r  <= row_r - POS_W'(1);
      res_last_r <= row_wrap && col_wrap;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_res.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_data_r.edge_res   <= sq_root;
      out_data_r.out_col    <= res_col_r;
      out_data_r.out_row    <= res_row_r;
      out_data_r.frame_last <= res_last_r;
    end
  end

  assign out_res.valid = out_valid_r;
  assign out_res.data  = out_data_r;

  `GME_ASSERT_NXT(a_accept_reads, clk, rst_n, accept, state_r == ST_READ)
  `GME_ASSERT_NXT(a_read_leaves, clk, rst_n, state_r == ST_READ,
                  state_r == ST_IDLE || state_r == ST_SQR)
  `GME_ASSERT_IMP(a_root_in_flight, clk, rst_n, state_r == ST_SQRT,
                  sq_stat.busy || sq_stat.done)
  `GME_ASSERT_NXT(a_load_shows, clk, rst_n, out_load, out_valid_r && state_r == ST_IDLE)

endmodule

>>> tb/sv/gradient_magnitude_edge_stream_test.sv
// ----------------------------------------------------------------------------
// gradient_magnitude_edge_stream_test
// streams raster pixels into the edge block under several frame sizes and
// handshake idling patterns; a local model of the 2x2 gradient and line
// store predicts every result beat, which is checked field by field in order
// ----------------------------------------------------------------------------
module gradient_magnitude_edge_stream_test;
  import gme_pkg::*;

  localparam int SETTLE_CYCLES    = 16;
  localparam int RANDOM_PIXELS    = 360;
  localparam int LONG_HOLD_CYCLES = 400;
  localparam int MAX_REPORTS      = 10;

  typedef enum int {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_t;
  typedef enum int {TEX_NOISE, TEX_BINARY, TEX_RAMP, TEX_DARK} texture_t;

  logic                 clk;
  logic                 rst_n;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [DIM_W-1:0]     cfg_data;

  gme_pix_if pix_ch();
  gme_res_if res_ch();

  gradient_magnitude_edge_stream u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_pix    (pix_ch),
    .out_res   (res_ch)
  );

  logic [PIX_W-1:0] pending_pixels [$];
  result_beat_t     expected_edges [$];
  int unsigned      pixels_queued = 0;
  int unsigned      pixels_taken  = 0;
  int unsigned      mismatches    = 0;
  int unsigned      sender_idle_pct;
  int unsigned      receiver_stall_pct;
  logic             long_hold;

  // edge model state
  logic [DIM_W-1:0] width_reg;
  logic [DIM_W-1:0] height_reg;
  logic [PIX_W-1:0] row_above [LS_DEPTH];
  logic [PIX_W-1:0] left_pix;
  logic [PIX_W-1:0] upper_left_pix;
  int unsigned      col_pos;
  int unsigned      row_pos;

  initial begin
    clk                = 1'b0;
    rst_n              = 1'b0;
    cfg_we             = 1'b0;
    cfg_index          = REG_IMAGE_WIDTH;
    cfg_data           = '0;
    pix_ch.valid       = 1'b0;
    pix_ch.data        = '0;
    res_ch.ready       = 1'b0;
    long_hold          = 1'b0;
    sender_idle_pct    = 0;
    receiver_stall_pct = 0;
    forever #2 clk = ~clk;
  end

  initial begin
    #3000000;
    $display("RESULT: ERROR");
    $finish;
  end

  function automatic logic [PIX_W-1:0] magnitude(input int unsigned sq);
    logic [PIX_W-1:0] root;
    int unsigned      trial;
    if (sq >= 65536) return EDGE_MAX;
    root = '0;
    for (int b = PIX_W - 1; b >= 0; b--) begin
      root[b] = 1'b1;
      trial = root;
      if (trial * trial > sq) root[b] = 1'b0;
    end
    return root;
  endfunction

  function automatic int unsigned bounded(input logic [DIM_W-1:0] v, input int unsigned hi);
    if (v < 2) return 2;
    if (v > hi) return hi;
    return v;
  endfunction

  task automatic predict_edge(input logic [PIX_W-1:0] br_pix);
    int unsigned  w;
    int unsigned  h;
    int           tl;
    int           tr;
    int           bl;
    int           br;
    int           gx;
    int           gy;
    result_beat_t r;
    w  = bounded(width_reg, LS_DEPTH);
    h  = bounded(height_reg, HEIGHT_MAX);
    tr = row_above[col_pos];
    br = br_pix;
    if (row_pos > 0 && col_pos > 0) begin
      tl           = upper_left_pix;
      bl           = left_pix;
      gx           = (tr + br) - (tl + bl);
      gy           = (bl + br) - (tl + tr);
      r.edge_res   = magnitude(gx * gx + gy * gy);
      r.out_col    = POS_W'(col_pos - 1);
      r.out_row    = POS_W'(row_pos - 1);
      r.frame_last = (row_pos + 1 >= h) && (col_pos + 1 >= w);
      expected_edges.push_back(r);
    end
    upper_left_pix    = PIX_W'(tr);
    row_above[col_pos] = br_pix;
    left_pix          = br_pix;
    col_pos++;
    if (col_pos >= w) begin
      col_pos = 0;
      row_pos++;
      if (row_pos >= h) row_pos = 0;
    end
  endtask

  task automatic check_edge(input result_beat_t got);
    result_beat_t want;
    if (expected_edges.size() == 0) begin
      mismatches++;
      if (mismatches <= MAX_REPORTS)
        $display("unexpected edge beat: edge %0d col %0d row %0d last %0b",
                 got.edge_res, got.out_col, got.out_row, got.frame_last);
    end else begin
      want = expected_edges.pop_front();
      if (got.edge_res !== want.edge_res || got.out_col !== want.out_col ||
          got.out_row !== want.out_row || got.frame_last !== want.frame_last) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("edge mismatch: exp edge %0d col %0d row %0d last %0b, got %0d %0d %0d %0b",
                   want.edge_res, want.out_col, want.out_row, want.frame_last,
                   got.edge_res, got.out_col, got.out_row, got.frame_last);
      end
    end
  endtask

  // pixel driver
  always @(posedge clk) begin
    if (!rst_n) begin
      pix_ch.valid <= 1'b0;
    end else begin
      if (pix_ch.valid && pix_ch.ready) begin
        pixels_taken++;
        predict_edge(pix_ch.data.pixel);
      end
      if (!pix_ch.valid || pix_ch.ready) begin
        if (pending_pixels.size() != 0 && $urandom_range(99) >= sender_idle_pct) begin
          pix_ch.valid      <= 1'b1;
          pix_ch.data.pixel <= pending_pixels.pop_front();
        end else begin
          pix_ch.valid <= 1'b0;
        end
      end
    end
  end

  // result monitor
  always @(posedge clk) begin
    if (!rst_n) begin
      res_ch.ready <= 1'b0;
    end else begin
      if (res_ch.valid && res_ch.ready) check_edge(res_ch.data);
      res_ch.ready <= !long_hold && ($urandom_range(99) >= receiver_stall_pct);
    end
  end

  task automatic set_idling(input idle_mode_t mode);
    case (mode)
      IDLE_SENDER: begin
        sender_idle_pct    = 53;
        receiver_stall_pct = 0;
      end
      IDLE_RECEIVER: begin
        sender_idle_pct    = 0;
        receiver_stall_pct = 53;
      end
      IDLE_BOTH: begin
        sender_idle_pct    = 7;
        receiver_stall_pct = 7;
      end
      default: begin
        sender_idle_pct    = 0;
        receiver_stall_pct = 0;
      end
    endcase
  endtask

  task automatic queue_pixel(input logic [PIX_W-1:0] p);
    pending_pixels.push_back(p);
    pixels_queued++;
  endtask

  task automatic wait_drained();
    while (pixels_taken != pixels_queued || expected_edges.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // both registers written back to back, frame restarts
  task automatic set_frame(input logic [DIM_W-1:0] w, input logic [DIM_W-1:0] h);
    cfg_we    <= 1'b1;
    cfg_index <= REG_IMAGE_WIDTH;
    cfg_data  <= w;
    @(posedge clk);
    cfg_index <= REG_IMAGE_HEIGHT;
    cfg_data  <= h;
    @(posedge clk);
    cfg_we         <= 1'b0;
    width_reg      = w;
    height_reg     = h;
    left_pix       = '0;
    upper_left_pix = '0;
    col_pos        = 0;
    row_pos        = 0;
  endtask

  task automatic hold_receiver();
    fork
      begin
        long_hold <= 1'b1;
        repeat (LONG_HOLD_CYCLES) @(posedge clk);
        long_hold <= 1'b0;
      end
    join_none
  endtask

  function automatic logic [PIX_W-1:0] pick_pixel(input texture_t tex,
                                                  input logic [PIX_W-1:0] prev);
    case (tex)
      TEX_BINARY: return $urandom_range(1) ? EDGE_MAX : '0;
      TEX_RAMP:   return PIX_W'(prev + $urandom_range(6) - 3);
      TEX_DARK:   return PIX_W'($urandom_range(3));
      default:    return PIX_W'($urandom_range(255));
    endcase
  endfunction

  task automatic queue_texture(input int unsigned count);
    texture_t         tex;
    logic [PIX_W-1:0] last;
    tex  = texture_t'($urandom_range(3));
    last = PIX_W'($urandom_range(255));
    for (int unsigned i = 0; i < count; i++) begin
      if ($urandom_range(15) == 0) tex = texture_t'($urandom_range(3));
      last = pick_pixel(tex, last);
      queue_pixel(last);
    end
  endtask

  initial begin
    logic [PIX_W-1:0] frame_a [$];
    logic [PIX_W-1:0] frame_b [$];
    logic [DIM_W-1:0] w_val;
    logic [DIM_W-1:0] h_val;
    int unsigned      count;
    int unsigned      random_sent;
    int unsigned      p;

    width_reg      = WIDTH_RESET;
    height_reg     = HEIGHT_RESET;
    left_pix       = '0;
    upper_left_pix = '0;
    col_pos        = 0;
    row_pos        = 0;
    foreach (row_above[i]) row_above[i] = '0;

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset size: one full top row and the start of the second
    set_idling(IDLE_RECEIVER);
    queue_texture(700);
    wait_drained();

    // directed: extremes, saturation, frame end and wrap, clamped sizes
    set_idling(IDLE_NONE);
    set_frame(12'd4, 12'd3);
    frame_a = '{8'd0, 8'd255, 8'd0, 8'd255, 8'd255, 8'd255, 8'd0, 8'd0,
                8'd1, 8'd2, 8'd128, 8'd127, 8'd0, 8'd0, 8'd0, 8'd0, 8'd255, 8'd1};
    foreach (frame_a[i]) queue_pixel(frame_a[i]);
    wait_drained();
    set_frame(12'd0, 12'd1);
    frame_b = '{8'd0, 8'd0, 8'd0, 8'd255, 8'd10, 8'd20, 8'd30, 8'd40};
    foreach (frame_b[i]) queue_pixel(frame_b[i]);
    wait_drained();

    random_sent = 0;
    p = 0;
    while (random_sent < RANDOM_PIXELS) begin
      set_idling(idle_mode_t'(p % 4));
      case ($urandom_range(9))
        0:       w_val = DIM_W'($urandom_range(1));
        1:       w_val = DIM_W'($urandom_range(LS_DEPTH, 4095));
        default: w_val = DIM_W'($urandom_range(2, 12));
      endcase
      case ($urandom_range(9))
        0:       h_val = DIM_W'($urandom_range(1));
        1:       h_val = DIM_W'($urandom_range(HEIGHT_MAX, 4095));
        default: h_val = DIM_W'($urandom_range(2, 6));
      endcase
      if (p == 2) w_val = 12'd5;
      set_frame(w_val, h_val);
      if (w_val > 12)
        count = $urandom_range(10, 60);
      else if (h_val <= 6 && $urandom_range(1))
        count = bounded(w_val, LS_DEPTH) * bounded(h_val, HEIGHT_MAX) * $urandom_range(1, 2);
      else
        count = $urandom_range(20, 120);
      if (p == 2) count = 120;
      if (p % 3 == 1) begin
        queue_texture(count / 2);
        wait_drained();
        queue_texture(count - count / 2);
      end else begin
        queue_texture(count);
      end
      if (p == 2) hold_receiver();
      random_sent += count;
      p++;
      wait_drained();
    end

    if (mismatches == 0 && expected_edges.size() == 0)
      $display("RESULT: OK");
    else
      $display("RESULT: ERROR");
    $finish;
  end

endmodule

>>> files.f
+incdir+design
design/gme_pkg.sv
design/gme_pix_if.sv
design/gme_res_if.sv
design/gme_line_ram.sv
design/gme_isqrt.sv
design/gradient_magnitude_edge_stream.sv
tb/sv/gradient_magnitude_edge_stream_test.sv
